### sv/kssc_pkg.sv
package kssc_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TBL_DEPTH = 256;
  localparam int unsigned ADDR_W  = $clog2(TBL_DEPTH);
  localparam int unsigned POS_W   = 3;
  localparam int unsigned DCNT_W  = $clog2(SEED_W);

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;
  localparam logic [ADDR_W-1:0] TOP_IDX = ADDR_W'(TBL_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_BUILD   = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_READ    = 2'd2
  } kssc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_LCG,
    ST_DIV,
    ST_SWAP_RD,
    ST_WR_I,
    ST_WR_J
  } kssc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic build_start;
    logic rd_lookup;
    logic lcg_step;
    logic div_step;
    logic rd_swap;
    logic wr_i;
    logic wr_j;
    logic next_i;
    logic out_load;
  } kssc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
    logic i_last;
    logic out_free;
  } kssc_sts_t;

endpackage

### sv/keyed_shuffle_substitution_cipher.sv
// Keyed shuffle substitution cipher.
// Input channel (in_valid / in_stall) carries one word: in_operation,
// in_data_byte, in_table_index. Build (0) reshuffles the 256-byte table
// from the low half of the key and clears the byte position; encrypt (1)
// returns table[in_data_byte] XOR key byte at the current position, then
// advances it; read (2) returns table[in_table_index]. Code 3 is dropped.
// Result channel (out_valid / out_stall) carries out_result_byte.
// Key port (cfg_valid / cfg_ready / cfg_cipher_key) is always ready; write
// it only while the block is idle. It does not rebuild the table.
// Encrypt and read go through the accept state, then the lookup state with
// the registered table read, which loads the output register once it is free;
// no new word is taken before that. A build holds in_stall for 255 swaps
// (LCG step, bit-serial remainder of the 32-bit seed, read, two writes
// through the single write port); it yields no word.
// Reset: table reads as the identity via cleared valid bits, key and
// position are zero, no word pending. A stalled receiver holds the
// result in the output register; the block then waits before loading
// the next one.
module keyed_shuffle_substitution_cipher import kssc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [BYTE_W-1:0] in_table_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_result_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KEY_W-1:0]  cfg_cipher_key
);

  kssc_cmd_t cmd;
  kssc_sts_t sts;

  assign cfg_ready = 1'b1;

  kssc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  kssc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .in_table_index  (in_table_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_cipher_key  (cfg_cipher_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte)
  );

  // result only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");

  // a new word appears only from a load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("out_valid rose without a load");

  // swap writes come as a pair
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_i |=> cmd.wr_j)
    else $error("swap left half done");

  // input held off once a build starts
  a_build_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.build_start |=> in_stall)
    else $error("input taken during build");

endmodule

### sv/kssc_ctrl.sv
module kssc_ctrl import kssc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_operation,
  input  kssc_sts_t   sts,
  output kssc_cmd_t   cmd,
  output logic        in_stall
);

  kssc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_BUILD) begin
            state_nxt = ST_LCG;
          end else if (in_operation == OP_ENCRYPT || in_operation == OP_READ) begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP:  if (sts.out_free) state_nxt = ST_IDLE;
      ST_LCG:     state_nxt = ST_DIV;
      ST_DIV:     if (sts.div_last) state_nxt = ST_SWAP_RD;
      ST_SWAP_RD: state_nxt = ST_WR_I;
      ST_WR_I:    state_nxt = ST_WR_J;
      ST_WR_J:    state_nxt = sts.i_last ? ST_IDLE : ST_LCG;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.build_start = (in_operation == OP_BUILD);
          cmd.rd_lookup   = (in_operation == OP_ENCRYPT || in_operation == OP_READ);
        end
      end
      ST_LOOKUP:  cmd.out_load = sts.out_free;
      ST_LCG:     cmd.lcg_step = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_SWAP_RD: cmd.rd_swap  = 1'b1;
      ST_WR_I:    cmd.wr_i     = 1'b1;
      ST_WR_J: begin
        cmd.wr_j   = 1'b1;
        cmd.next_i = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### sv/kssc_dp.sv
module kssc_dp import kssc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  kssc_cmd_t         cmd,
  output kssc_sts_t         sts,
  input  logic [1:0]        in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [BYTE_W-1:0] in_table_index,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [KEY_W-1:0]  cfg_cipher_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_result_byte
);

  // table store; entries without a valid bit read as their own index
  logic [BYTE_W-1:0]    tbl_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] tbl_vld_r;

  logic [KEY_W-1:0]  key_r;
  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [SEED_W-1:0] shift_r;
  logic [ADDR_W:0]   rem_r, rem_nxt, div_try, divisor;
  logic [DCNT_W-1:0] dcnt_r;
  logic [ADDR_W-1:0] i_r;
  logic [POS_W-1:0]  pos_r;
  logic              enc_r;

  logic [ADDR_W-1:0] addr_a, addr_b, wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] rda_mem_r, rdb_mem_r;
  logic              rda_vld_r, rdb_vld_r;
  logic [ADDR_W-1:0] rda_addr_r, rdb_addr_r;
  logic [BYTE_W-1:0] rda, rdb;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r, result;

  // LCG step
  assign seed_nxt = seed_r * LCG_MUL + LCG_ADD;

  // restoring remainder, one dividend bit per cycle
  assign divisor = {1'b0, i_r} + (ADDR_W+1)'(1);
  assign div_try = {rem_r[ADDR_W-1:0], shift_r[SEED_W-1]};
  assign rem_nxt = (div_try >= divisor) ? (div_try - divisor) : div_try;

  assign addr_a  = cmd.rd_swap ? i_r
                 : ((in_operation == OP_ENCRYPT) ? in_data_byte : in_table_index);
  assign addr_b  = rem_r[ADDR_W-1:0];
  assign wr_addr = cmd.wr_i ? i_r : rem_r[ADDR_W-1:0];
  assign wr_data = cmd.wr_i ? rdb : rda;

  assign rda = rda_vld_r ? rda_mem_r : rda_addr_r;
  assign rdb = rdb_vld_r ? rdb_mem_r : rdb_addr_r;

  assign result = enc_r ? (rda ^ key_r[{pos_r, 3'b000} +: BYTE_W]) : rda;

  always_ff @(posedge clk) begin
    if (cmd.wr_i || cmd.wr_j) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_lookup || cmd.rd_swap) begin
      rda_mem_r  <= tbl_mem[addr_a];
      rda_vld_r  <= tbl_vld_r[addr_a];
      rda_addr_r <= addr_a;
    end
    if (cmd.rd_swap) begin
      rdb_mem_r  <= tbl_mem[addr_b];
      rdb_vld_r  <= tbl_vld_r[addr_b];
      rdb_addr_r <= addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r   <= '0;
      key_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) key_r <= cfg_cipher_key;
      if (cmd.build_start) begin
        tbl_vld_r <= '0;
        pos_r     <= '0;
      end else if (cmd.wr_i || cmd.wr_j) begin
        tbl_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.out_load && enc_r) pos_r <= pos_r + POS_W'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      seed_r <= key_r[SEED_W-1:0];
      i_r    <= TOP_IDX;
    end
    if (cmd.lcg_step) begin
      seed_r  <= seed_nxt;
      shift_r <= seed_nxt;
      rem_r   <= '0;
      dcnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r   <= rem_nxt;
      shift_r <= {shift_r[SEED_W-2:0], 1'b0};
      dcnt_r  <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.next_i) i_r <= i_r - ADDR_W'(1);
    if (cmd.rd_lookup) enc_r <= (in_operation == OP_ENCRYPT);
    if (cmd.out_load) out_byte_r <= result;
  end

  assign sts.div_last = (dcnt_r == DCNT_W'(SEED_W - 1));
  assign sts.i_last   = (i_r == ADDR_W'(1));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_byte_r;

endmodule

### tb/cipher_result_checker.sv
// Watches the three channels, keeps its own copy of the substitution table,
// byte position and key, and compares every result word with the oldest
// predicted byte.
module cipher_result_checker
  import kssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [BYTE_W-1:0] in_table_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [BYTE_W-1:0] out_result_byte,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [KEY_W-1:0]  cfg_cipher_key,
  output int                mismatches,
  output int                outstanding,
  output int                compared
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BYTE_W-1:0] perm_tbl [TBL_DEPTH];
  logic [POS_W-1:0]  key_pos;
  logic [KEY_W-1:0]  key_reg;
  logic [BYTE_W-1:0] cipher_due [$];
  int                errs;
  int                seen;

  // Identity fill, then Fisher-Yates driven by the LCG on the key's low half.
  function automatic void reshuffle();
    logic [SEED_W-1:0] seed;
    logic [SEED_W-1:0] pick;
    logic [BYTE_W-1:0] tmp;
    for (int k = 0; k < TBL_DEPTH; k++) perm_tbl[ADDR_W'(k)] = BYTE_W'(k);
    seed = key_reg[SEED_W-1:0];
    for (int i = TBL_DEPTH - 1; i > 0; i--) begin
      seed = seed * LCG_MUL + LCG_ADD;
      pick = seed % SEED_W'(i + 1);
      tmp = perm_tbl[ADDR_W'(i)];
      perm_tbl[ADDR_W'(i)] = perm_tbl[pick[ADDR_W-1:0]];
      perm_tbl[pick[ADDR_W-1:0]] = tmp;
    end
    key_pos = '0;
  endfunction

  function automatic logic [BYTE_W-1:0] key_byte(logic [POS_W-1:0] p);
    return BYTE_W'(key_reg >> {p, 3'b000});
  endfunction

  always @(posedge clk) begin : watch
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      for (int k = 0; k < TBL_DEPTH; k++) perm_tbl[ADDR_W'(k)] = BYTE_W'(k);
      key_pos = '0;
      key_reg = '0;
      cipher_due.delete();
      errs = 0;
      seen = 0;
    end else begin
      // results first: a word accepted this edge cannot answer one
      // accepted at the same edge
      if (out_valid && !out_stall) begin
        if (cipher_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word, expected none actual %02h",
                   $time, out_result_byte);
        end else begin
          want = cipher_due.pop_front();
          seen++;
          if (out_result_byte !== want) begin
            errs++;
            $display("%0t: result_byte mismatch, expected %02h actual %02h",
                     $time, want, out_result_byte);
          end
        end
      end
      if (cfg_valid && cfg_ready) key_reg = cfg_cipher_key;
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_BUILD: reshuffle();
          OP_ENCRYPT: begin
            cipher_due.push_back(perm_tbl[in_data_byte] ^ key_byte(key_pos));
            key_pos = key_pos + POS_W'(1);
          end
          OP_READ: cipher_due.push_back(perm_tbl[in_table_index]);
          default: ;
        endcase
      end
    end
    mismatches  <= errs;
    outstanding <= cipher_due.size();
    compared    <= seen;
  end

endmodule

### tb/tb_keyed_shuffle_substitution_cipher.sv
// Stimulus and verdict for the keyed shuffle cipher; prediction and
// comparison live in the checker beside the block.
module tb_keyed_shuffle_substitution_cipher
  import kssc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_IGNORED  = 2'd3;  // dropped by the block
  localparam int BUILD_CYCLES = 9180;         // one full reshuffle
  localparam int SETTLE       = BUILD_CYCLES + 220;
  localparam int QUIET_LIMIT  = 4 * SETTLE;   // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 400;          // long receiver hold-off
  localparam int N_PHASES     = 6;
  localparam int PHASE_WORDS  = 195;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = OP_BUILD;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic [BYTE_W-1:0] in_table_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_result_byte;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [KEY_W-1:0]  cfg_cipher_key = '0;

  int mismatches;
  int outstanding;
  int compared;

  // idle rates in percent, set per phase
  int tx_idle_pct = 28;
  int rx_idle_pct = 59;

  // hold-off request: main process toggles, receiver process follows
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   quiet_cnt = 0;
  int   n_words = 0;
  int   n_builds = 0;
  int   n_keys = 0;

  always #2 clk = ~clk;

  keyed_shuffle_substitution_cipher u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .in_table_index (in_table_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_byte(out_result_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cipher_key (cfg_cipher_key)
  );

  cipher_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .in_table_index (in_table_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_byte(out_result_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cipher_key (cfg_cipher_key),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .compared       (compared)
  );

  // Receiver: random stall, or a counted hold-off when asked for one.
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: a build keeps in_stall high for its whole shuffle, so the
  // limit sits well above that and above the settle wait.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words still due",
                 $time, quiet_cnt, outstanding);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // Offer one word and return at the edge that accepts it. in_valid stays
  // high on return so back-to-back words need no extra step.
  task automatic send_word(input logic [1:0] op, input logic [BYTE_W-1:0] d,
                           input logic [BYTE_W-1:0] x);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_data_byte   <= d;
    in_table_index <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_IGNORED) n_words++;
    if (op == OP_BUILD) n_builds++;
  endtask

  // Drain every expected word, then let any build still running finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_key(input logic [KEY_W-1:0] k);
    cfg_valid      <= 1'b1;
    cfg_cipher_key <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_keys++;
  endtask

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 3)       return OP_BUILD;
    else if (r < 58) return OP_ENCRYPT;
    else if (r < 95) return OP_READ;
    else             return OP_IGNORED;
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] phase_key;
    logic [1:0]       op;
    int               sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity table under the reset key, code 3 dropped,
    // build with key 0, position wrap past 8, build clears the position.
    send_word(OP_READ, 8'h00, 8'h00);
    send_word(OP_READ, 8'hFF, 8'hFF);
    send_word(OP_ENCRYPT, 8'hFF, 8'h00);
    send_word(OP_ENCRYPT, 8'h00, 8'hFF);
    send_word(OP_IGNORED, 8'hA5, 8'h5A);
    send_word(OP_BUILD, 8'hFF, 8'hFF);
    send_word(OP_READ, 8'h00, 8'h00);
    send_word(OP_READ, 8'h5A, 8'hFF);
    send_word(OP_READ, 8'hA5, 8'h80);
    for (int k = 0; k < 9; k++)
      send_word(OP_ENCRYPT, (k[0] ? 8'hFF : 8'h00), BYTE_W'($urandom));
    send_word(OP_IGNORED, 8'hFF, 8'hFF);
    send_word(OP_READ, 8'h00, 8'h01);
    send_word(OP_BUILD, 8'h00, 8'h00);
    send_word(OP_ENCRYPT, 8'hFF, 8'h00);
    send_word(OP_ENCRYPT, 8'h7F, 8'h00);

    // Random phases, each with its own key: all ones, random, all zeros, each half key, random.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       phase_key = '1;
        1:       phase_key = {$urandom, $urandom};
        2:       phase_key = '0;
        3:       phase_key = {32'hFFFF_FFFF, 32'h0000_0000};
        4:       phase_key = {32'h0000_0000, 32'hFFFF_FFFF};
        default: phase_key = {$urandom, $urandom};
      endcase
      // sender 28 / receiver 59, then swapped, then no idling
      tx_idle_pct <= (ph < 2) ? 28 : (ph < 4) ? 59 : 0;
      rx_idle_pct <= (ph < 2) ? 59 : (ph < 4) ? 28 : 0;
      write_key(phase_key);

      // old table under the new key, then a fresh table
      send_word(OP_ENCRYPT, BYTE_W'($urandom), BYTE_W'($urandom));
      send_word(OP_READ, BYTE_W'($urandom), BYTE_W'($urandom));
      send_word(OP_BUILD, BYTE_W'($urandom), BYTE_W'($urandom));

      sent = 0;
      while (sent < PHASE_WORDS) begin
        if (ph == 4 && sent == 40) hold_tog <= ~hold_tog;
        op = pick_op();
        send_word(op, BYTE_W'($urandom), BYTE_W'($urandom));
        if (op != OP_IGNORED) sent++;
      end
    end

    wait_idle();

    $display("covered %0d words incl. %0d table builds under %0d key settings,",
             n_words, n_builds, n_keys + 1);
    $display("three idle mixes and a %0d-cycle result hold-off; %0d bytes compared",
             HOLD_CYCLES, compared);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
